/* rtl/core/prc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants and types of the page replacement block.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int ProcBits  = 8;
   localparam int PageBits  = 8;
   localparam int FrameBits = 8;
   localparam int Frames    = 1 << FrameBits;
   localparam int IdxBits   = ProcBits + PageBits;
   localparam int CntBits   = 32;
   localparam int FcBits    = 9;

   localparam logic [1:0] ModeInfinite = 2'd0;
   localparam logic [1:0] ModeFifo     = 2'd1;
   localparam logic [1:0] ModeClock    = 2'd2;
   localparam logic [1:0] ModeRandom   = 2'd3;

   localparam logic RegPolicy = 1'b0;
   localparam logic RegFrames = 1'b1;

   // page table word: loaded, frame, hit count, miss count
   typedef struct packed {
      logic                 loaded;
      logic [FrameBits-1:0] frame;
      logic [CntBits-1:0]   hits;
      logic [CntBits-1:0]   misses;
   } entry_type;

   localparam int EntryBits = $bits(entry_type);

   // frame table word: vacant, referenced, owner index
   typedef struct packed {
      logic               vacant;
      logic               refd;
      logic [IdxBits-1:0] owner;
   } frame_type;

   localparam int FrameWBits = $bits(frame_type);

   typedef struct packed {
      logic                 hit;
      logic [FrameBits-1:0] frame_used;
      logic                 evicted;
      logic [ProcBits-1:0]  evicted_pid;
      logic [PageBits-1:0]  evicted_page;
      logic [CntBits-1:0]   page_hit_count;
      logic [CntBits-1:0]   page_miss_count;
      logic [CntBits-1:0]   total_hits;
      logic [CntBits-1:0]   total_misses;
      logic [CntBits-1:0]   access_count;
   } rsp_type;

   typedef struct packed {
      logic [ProcBits-1:0]  pid;
      logic [PageBits-1:0]  page;
      logic [FrameBits-1:0] random_frame;
   } req_type;

   function automatic logic [CntBits-1:0] sat_inc(input logic [CntBits-1:0] v);
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

endpackage

/* rtl/core/prc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready channels: request, response and register write.
// ----------------------------------------------------------------------------
interface prc_req_if import prc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface prc_rsp_if import prc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface prc_csr_if import prc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        index;
   logic [FcBits-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/prc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* rtl/core/prc_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_engine
// Sequencer: clears the tables, then runs one access at a time through
// read-modify-write of the page table and frame table.
// ----------------------------------------------------------------------------
module prc_engine import prc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          mode,
   input  logic [FcBits-1:0]   frame_count,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);
   localparam logic [3:0] StClear = 4'd0;
   localparam logic [3:0] StIdle  = 4'd1;
   localparam logic [3:0] StRdPt  = 4'd2;
   localparam logic [3:0] StDec   = 4'd3;
   localparam logic [3:0] StRdFr  = 4'd4;
   localparam logic [3:0] StWalk  = 4'd5;
   localparam logic [3:0] StVict  = 4'd6;
   localparam logic [3:0] StRdOwn = 4'd7;
   localparam logic [3:0] StOwn   = 4'd8;
   localparam logic [3:0] StWrPt  = 4'd9;
   localparam logic [3:0] StHitFr = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [IdxBits:0]     clr_ff, clr_in;
   req_type              req_ff, req_in;
   entry_type            ent_ff, ent_in;
   logic [FrameBits-1:0] hand_ff, hand_in;
   logic [FrameBits-1:0] vic_ff, vic_in;
   logic [IdxBits-1:0]   own_ff, own_in;
   logic                 occ_ff, occ_in;
   logic                 walk_ff, walk_in;
   logic [CntBits-1:0]   th_ff, th_in, tm_ff, tm_in, ta_ff, ta_in;
   logic                 rv_ff, rv_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 hitf_ff, hitf_in;

   logic                 pt_we, fr_we;
   logic [IdxBits-1:0]   pt_addr;
   logic [FrameBits-1:0] fr_addr;
   entry_type            pt_wd, pt_rd;
   frame_type            fr_wd, fr_rd;
   logic [FcBits-1:0]    n;
   logic [IdxBits-1:0]   idx;
   logic [FrameBits-1:0] hand_adv;
   logic [FcBits-1:0]    hand_inc;

   prc_ram #(.Width(EntryBits), .Depth(1 << IdxBits)) u_pt (
      .clock(clock), .we(pt_we), .addr(pt_addr), .wdata(pt_wd), .rdata(pt_rd));
   prc_ram #(.Width(FrameWBits), .Depth(Frames)) u_fr (
      .clock(clock), .we(fr_we), .addr(fr_addr), .wdata(fr_wd), .rdata(fr_rd));

   assign n = (frame_count == '0 || frame_count > FcBits'(Frames)) ?
              FcBits'(Frames) : frame_count;
   assign idx = {req_ff.pid, req_ff.page};
   assign hand_inc = {1'b0, hand_ff} + 1'b1;
   assign hand_adv = (hand_inc >= n) ? '0 : hand_inc[FrameBits-1:0];
   assign req_ready = (state_ff == StIdle) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // hit flag latched at decode
   assign hitf_in = (state_ff == StDec) ? pt_rd.loaded : hitf_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; req_in = req_ff; ent_in = ent_ff;
      hand_in = hand_ff; vic_in = vic_ff; own_in = own_ff; occ_in = occ_ff;
      walk_in = walk_ff;
      th_in = th_ff; tm_in = tm_ff; ta_in = ta_ff;
      rv_in = rv_ff && !rsp_ready; rsp_in = rsp_ff;
      pt_we = 1'b0; fr_we = 1'b0;
      pt_addr = idx; fr_addr = hand_ff; pt_wd = ent_ff; fr_wd = fr_rd;
      case (state_ff)
         StClear: begin
            pt_we = 1'b1; pt_addr = clr_ff[IdxBits-1:0]; pt_wd = '0;
            fr_we = 1'b1; fr_addr = clr_ff[FrameBits-1:0];
            fr_wd = '{vacant: 1'b1, refd: 1'b0, owner: '0};
            clr_in = clr_ff + 1'b1;
            if (clr_ff[IdxBits-1:0] == IdxBits'((1 << IdxBits) - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               state_in = StRdPt;
            end
         end
         StRdPt: begin
            state_in = StDec;
         end
         StDec: begin
            ent_in = pt_rd;
            ta_in = sat_inc(ta_ff);
            occ_in = 1'b0;
            walk_in = 1'b0;
            if (pt_rd.loaded) begin
               ent_in.hits = sat_inc(pt_rd.hits);
               th_in = sat_inc(th_ff);
               fr_addr = pt_rd.frame;
               state_in = (mode == ModeClock) ? StHitFr : StWrPt;
            end else begin
               ent_in.misses = sat_inc(pt_rd.misses);
               ent_in.loaded = 1'b1;
               tm_in = sat_inc(tm_ff);
               if (mode == ModeInfinite) begin
                  ent_in.frame = '0;
                  state_in = StWrPt;
               end else if (mode == ModeRandom) begin
                  vic_in = ({1'b0, req_ff.random_frame} < n) ? req_ff.random_frame : '0;
                  fr_addr = vic_in;
                  state_in = StVict;
               end else begin
                  if ({1'b0, hand_ff} >= n) begin
                     hand_in = '0;
                  end
                  fr_addr = hand_in;
                  state_in = (mode == ModeClock) ? StWalk : StRdFr;
               end
            end
         end
         StHitFr: begin
            fr_addr = ent_ff.frame;
            fr_we = 1'b1;
            fr_wd = fr_rd; fr_wd.refd = 1'b1;
            state_in = StWrPt;
         end
         StWalk: begin
            // fr_rd holds frame at hand_ff; vacancy only checked at the start
            if (fr_rd.refd && (walk_ff || !fr_rd.vacant)) begin
               fr_we = 1'b1; fr_addr = hand_ff;
               fr_wd = fr_rd; fr_wd.refd = 1'b0;
               hand_in = hand_adv;
               walk_in = 1'b1;
               state_in = StRdFr;
            end else begin
               vic_in = hand_ff; hand_in = hand_adv;
               fr_addr = hand_ff;
               state_in = StVict;
            end
         end
         StRdFr: begin
            fr_addr = hand_ff;
            if (mode == ModeClock) begin
               state_in = StWalk;
            end else begin
               vic_in = hand_ff; hand_in = hand_adv;
               state_in = StVict;
            end
         end
         StVict: begin
            // fr_rd holds victim frame
            fr_addr = vic_ff;
            fr_we = 1'b1;
            fr_wd = '{vacant: 1'b0, refd: 1'b0, owner: idx};
            occ_in = !fr_rd.vacant;
            own_in = fr_rd.owner;
            ent_in.frame = vic_ff;
            pt_addr = fr_rd.owner;
            state_in = fr_rd.vacant ? StWrPt : StRdOwn;
         end
         StRdOwn: begin
            pt_addr = own_ff;
            state_in = StOwn;
         end
         StOwn: begin
            pt_addr = own_ff;
            pt_wd = '{loaded: 1'b0, frame: '0, hits: pt_rd.hits, misses: pt_rd.misses};
            if (pt_rd.loaded && pt_rd.frame == vic_ff && own_ff != idx) begin
               pt_we = 1'b1;
            end
            state_in = StWrPt;
         end
         StWrPt: begin
            pt_we = 1'b1; pt_addr = idx; pt_wd = ent_ff;
            rv_in = 1'b1;
            rsp_in.hit = hitf_ff;
            rsp_in.frame_used = ent_ff.frame;
            rsp_in.evicted = occ_ff;
            rsp_in.evicted_pid = occ_ff ? own_ff[IdxBits-1:PageBits] : '0;
            rsp_in.evicted_page = occ_ff ? own_ff[PageBits-1:0] : '0;
            rsp_in.page_hit_count = ent_ff.hits;
            rsp_in.page_miss_count = ent_ff.misses;
            rsp_in.total_hits = th_ff;
            rsp_in.total_misses = tm_ff;
            rsp_in.access_count = ta_ff;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear; clr_ff <= '0; hand_ff <= '0;
         th_ff <= '0; tm_ff <= '0; ta_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; hand_ff <= hand_in;
         th_ff <= th_in; tm_ff <= tm_in; ta_ff <= ta_in; rv_ff <= rv_in;
      end
      req_ff <= req_in; ent_ff <= ent_in; vic_ff <= vic_in;
      own_ff <= own_in; occ_ff <= occ_in; hitf_ff <= hitf_in;
      walk_ff <= walk_in;
      rsp_ff <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken with response pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StWrPt |=> rsp_valid)
      else $error("no response after table write");
endmodule

/* rtl/core/page_replacement_clock_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_clock_fifo
// Paging unit with FIFO, second-chance clock, random or infinite policy.
// Usage: one req word (pid, page, random_frame) gives one rsp word.
// Page table (64K entries with per-page counts) and frame table (256 entries)
// live in single-port RAMs and are updated by read-modify-write.
// After reset the tables are swept clear and req_ready stays low during
// the sweep. csr writes (0 policy_mode, 1 frame_count) are taken at once.
// One access at a time; the next req is taken the cycle after the previous
// rsp has been accepted. A stalled rsp holds its word. A clock-mode hit
// sets its frame's referenced bit; a miss outside infinite mode claims a
// victim frame and, if it was occupied, unloads the old owner's entry if it
// still maps that frame; the clock hand clears and skips referenced frames.
// ----------------------------------------------------------------------------
module page_replacement_clock_fifo import prc_pkg::*; (
   input logic      clock,
   input logic      reset,
   prc_req_if.sink  req,
   prc_rsp_if.source rsp,
   prc_csr_if.sink  csr
);
   logic [1:0]        mode_ff;
   logic [FcBits-1:0] fc_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeClock;
         fc_ff   <= FcBits'(Frames);
      end else if (csr.valid) begin
         if (csr.index == RegPolicy) begin
            mode_ff <= csr.wdata[1:0];
         end
         if (csr.index == RegFrames) begin
            fc_ff <= csr.wdata;
         end
      end
   end

   prc_engine u_engine (
      .clock(clock), .reset(reset), .mode(mode_ff), .frame_count(fc_ff),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
endmodule

/* tb/prc_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_tb_pkg
// Paging predictor and response scoreboard for the page replacement block.
// ----------------------------------------------------------------------------
package prc_tb_pkg;
   import prc_pkg::*;

   class paging_scoreboard;
      logic [8:0]  tbl_slot [int];
      logic [31:0] tbl_hits [int];
      logic [31:0] tbl_miss [int];
      logic [15:0] owner [Frames];
      bit          vacant [Frames];
      bit          refd [Frames];
      int          hand;
      logic [31:0] hit_sum, miss_sum, acc_sum;
      logic [1:0]  mode;
      int          nframes;
      rsp_type     pending [$];
      int          mismatches;

      function new();
         for (int f = 0; f < Frames; f++) begin
            owner[f] = '0;
            vacant[f] = 1;
            refd[f] = 0;
         end
         hand = 0;
         hit_sum = 0;
         miss_sum = 0;
         acc_sum = 0;
         mode = ModeClock;
         nframes = 256;
         mismatches = 0;
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (&v) ? v : v + 1;
      endfunction

      function void write_reg(logic idx, logic [8:0] v);
         if (idx == RegPolicy) mode = v[1:0];
         else nframes = (v == 0 || v > 256) ? 256 : v;
      endfunction

      function void note_access(req_type r);
         rsp_type o;
         int key, fr, okey;
         logic [8:0] slot;
         key = {r.pid, r.page};
         o = '0;
         if (!tbl_slot.exists(key)) begin
            tbl_slot[key] = '0;
            tbl_hits[key] = '0;
            tbl_miss[key] = '0;
         end
         acc_sum = bump(acc_sum);
         slot = tbl_slot[key];
         if (slot[8]) begin
            o.hit = 1;
            fr = slot[7:0];
            tbl_hits[key] = bump(tbl_hits[key]);
            hit_sum = bump(hit_sum);
            if (mode == ModeClock) refd[fr] = 1;
         end else begin
            tbl_miss[key] = bump(tbl_miss[key]);
            miss_sum = bump(miss_sum);
            fr = 0;
            if (mode != ModeInfinite) begin
               if (mode == ModeRandom) begin
                  fr = (r.random_frame < nframes) ? r.random_frame : 0;
               end else begin
                  if (hand >= nframes) hand = 0;
                  if (mode == ModeClock && !vacant[hand])
                     while (refd[hand]) begin
                        refd[hand] = 0;
                        hand++;
                        if (hand >= nframes) hand = 0;
                     end
                  fr = hand;
                  hand++;
                  if (hand >= nframes) hand = 0;
               end
               if (!vacant[fr]) begin
                  okey = owner[fr];
                  o.evicted = 1;
                  o.evicted_pid = owner[fr][15:8];
                  o.evicted_page = owner[fr][7:0];
                  if (tbl_slot.exists(okey) && tbl_slot[okey] == {1'b1, fr[7:0]})
                     tbl_slot[okey] = '0;
               end
               owner[fr] = key[15:0];
               vacant[fr] = 0;
               refd[fr] = 0;
            end
            tbl_slot[key] = {1'b1, fr[7:0]};
         end
         o.frame_used = fr[7:0];
         o.page_hit_count = tbl_hits[key];
         o.page_miss_count = tbl_miss[key];
         o.total_hits = hit_sum;
         o.total_misses = miss_sum;
         o.access_count = acc_sum;
         pending.push_back(o);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got.hit !== exp.hit || got.frame_used !== exp.frame_used ||
             got.evicted !== exp.evicted || got.evicted_pid !== exp.evicted_pid ||
             got.evicted_page !== exp.evicted_page ||
             got.page_hit_count !== exp.page_hit_count ||
             got.page_miss_count !== exp.page_miss_count ||
             got.total_hits !== exp.total_hits ||
             got.total_misses !== exp.total_misses ||
             got.access_count !== exp.access_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: exp %h got %h", exp, got);
         end
      endfunction
   endclass

endpackage

/* tb/page_replacement_clock_fifo_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_clock_fifo_tb
// Drives page accesses under every replacement policy and varied frame counts,
// predicts hits, frames, evictions and counts, and checks each rsp word.
// ----------------------------------------------------------------------------
module page_replacement_clock_fifo_tb;
   import prc_pkg::*;
   import prc_tb_pkg::*;

   localparam int WatchLimit = 200000;

   logic clock = 0;
   logic reset = 1;
   int   idle_cycles = 0;

   prc_req_if req ();
   prc_rsp_if rsp ();
   prc_csr_if csr ();

   paging_scoreboard sb = new();

   page_replacement_clock_fifo i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_access(req.data);
         if (rsp.valid && rsp.ready) sb.check_rsp(rsp.data);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr.valid && csr.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("page_replacement_clock_fifo_tb failed");
            $finish;
         end
      end
   end

   // receiver stall pattern
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase++;
      if (reset) rsp.ready <= 0;
      else if (stall_phase % 500 < 150) rsp.ready <= 1;
      else rsp.ready <= ($urandom_range(0, 99) < 65);
   end

   task automatic write_reg(logic idx, logic [8:0] v);
      @(negedge clock);
      csr.valid <= 1;
      csr.index <= idx;
      csr.wdata <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr.valid <= 0;
   endtask

   task automatic send(logic [7:0] pid, logic [7:0] page, logic [7:0] rf);
      req_type w;
      w.pid = pid;
      w.page = page;
      w.random_frame = rf;
      req.valid <= 1;
      req.data <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic random_phase(int items);
      int burst;
      logic [7:0] pid, page;
      burst = 0;
      for (int i = 0; i < items; i++) begin
         if (burst == 0) begin
            req.valid <= 0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst = $urandom_range(1, 20);
         end
         burst--;
         if ($urandom_range(0, 99) < 75) begin
            pid = 8'($urandom_range(0, 3));
            page = 8'($urandom_range(0, 11));
         end else begin
            pid = 8'($urandom);
            page = 8'($urandom);
         end
         send(pid, page, 8'($urandom));
      end
      drain();
   endtask

   initial begin
      req.valid = 0;
      req.data = '0;
      csr.valid = 0;
      csr.index = RegPolicy;
      csr.wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: clock mode, full frames, extremes
      send(8'h00, 8'h00, 8'h00);
      send(8'h00, 8'h00, 8'h00);
      send(8'hFF, 8'hFF, 8'hFF);
      send(8'hFF, 8'hFF, 8'hFF);
      drain();
      write_reg(RegFrames, 9'd2);
      send(8'h01, 8'h01, 8'h00);
      send(8'h01, 8'h01, 8'h00);
      send(8'h02, 8'h02, 8'h00);
      send(8'h03, 8'h03, 8'h00);
      send(8'h01, 8'h01, 8'h00);
      drain();
      write_reg(RegPolicy, 9'(ModeRandom));
      write_reg(RegFrames, 9'd3);
      send(8'h10, 8'h01, 8'd2);
      send(8'h10, 8'h02, 8'd200);
      send(8'h10, 8'h03, 8'd2);
      drain();
      write_reg(RegPolicy, 9'(ModeInfinite));
      write_reg(RegFrames, 9'd0);
      send(8'h20, 8'h05, 8'h00);
      send(8'h20, 8'h05, 8'h00);
      drain();
      write_reg(RegPolicy, 9'(ModeFifo));
      write_reg(RegFrames, 9'd1);
      send(8'hAA, 8'h55, 8'h00);
      send(8'h55, 8'hAA, 8'h00);
      send(8'hAA, 8'h55, 8'h00);
      drain();
      write_reg(RegFrames, 9'd511);
      send(8'h30, 8'h30, 8'h00);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         write_reg(RegPolicy, 9'(ph % 4));
         case (ph % 3)
            0: write_reg(RegFrames, 9'($urandom_range(1, 8)));
            1: write_reg(RegFrames, 9'($urandom_range(1, 300)));
            default: write_reg(RegFrames, 9'd256);
         endcase
         random_phase(75);
      end

      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("page_replacement_clock_fifo_tb passed");
      else
         $display("page_replacement_clock_fifo_tb failed");
      $finish;
   end
endmodule
